/* src/skvlt_pkg.sv */
// Package for the sorted key/value leaf table: sizes, operation and status codes,
// request and response payloads. No dependencies.
`timescale 1ns / 1ps
package skvlt_pkg;
    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CW         = 7;    // slot and count width
    localparam int AW         = 6;    // entry address width

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_RSVD    = 2'd3
    } status_t;

    typedef struct packed {
        op_t         kind;
        logic [31:0] search_key;
        logic [31:0] entry_value;
    } req_t;

    typedef struct packed {
        status_t       status;
        logic [31:0]   found_value;
        logic [CW-1:0] slot;
        logic [CW-1:0] entry_count;
    } rsp_t;
endpackage

/* src/skvlt_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on skvlt_pkg.
`timescale 1ns / 1ps
interface skvlt_req_if;
    logic            valid;
    logic            ready;
    skvlt_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface skvlt_rsp_if;
    logic            valid;
    logic            ready;
    skvlt_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/skvlt_front.sv */
// Front end: accepts requests and holds them in a two-entry queue.
// Uses skvlt_pkg.
`timescale 1ns / 1ps
module skvlt_front #(
    parameter int W = 66
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         q_valid,
    input  logic         q_ready,
    output logic [W-1:0] q_data
);
    import skvlt_pkg::*;

    logic [W-1:0] slot_reg [2];
    logic [1:0]   fill_reg, fill_next;
    logic         rd_reg, wr_reg;
    logic         push, pop;

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_data   = slot_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
            rd_reg   <= 1'b0;
            wr_reg   <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_data;
        end
    end
endmodule

/* src/skvlt_back.sv */
// Back end: binary search and entry shifting over one key/value memory.
// Uses skvlt_pkg.
`timescale 1ns / 1ps
module skvlt_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  skvlt_pkg::op_t                   q_kind,
    input  logic [skvlt_pkg::KEY_BITS-1:0]   q_key,
    input  logic [skvlt_pkg::VALUE_BITS-1:0] q_value,
    output logic                             r_valid,
    input  logic                             r_ready,
    output skvlt_pkg::status_t               r_status,
    output logic [skvlt_pkg::VALUE_BITS-1:0] r_value,
    output logic [skvlt_pkg::CW-1:0]         r_slot,
    output logic [skvlt_pkg::CW-1:0]         r_count
);
    import skvlt_pkg::*;

    localparam int EW = KEY_BITS + VALUE_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_PROBE, S_WAIT, S_DECIDE, S_MATCH, S_SHIFT, S_MOVE, S_OUT
    } state_t;

    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] rd_reg;

    state_t                state_reg;
    op_t                   op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CW-1:0]         lo_reg, hi_reg, cnt_reg, idx_reg;
    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [EW-1:0]         wr_data;
    logic [CW-1:0]         mid;
    logic [KEY_BITS-1:0]   rd_key;
    logic                  go_right;
    logic                  shift_more;

    assign mid      = CW'((lo_reg + hi_reg) >> 1);
    assign rd_key   = rd_reg[EW-1:VALUE_BITS];
    assign go_right = (op_reg == OP_INSERT) ? (rd_key <= key_reg) : (rd_key < key_reg);
    // insert walks down from count to lo, erase walks up from the hit
    assign shift_more = (op_reg == OP_INSERT) ? (idx_reg > lo_reg)
                                              : (CW'(idx_reg + 1'b1) < cnt_reg);
    assign q_ready  = (state_reg == S_IDLE);
    assign r_valid  = (state_reg == S_OUT);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = mid[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_reg;
        case (state_reg)
            S_PROBE:
            begin
                rd_en = (lo_reg < hi_reg);
            end
            S_DECIDE:
            begin
                // find/erase read the entry at lo for the equality test
                if (op_reg != OP_INSERT && lo_reg < cnt_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = lo_reg[AW-1:0];
                end
            end
            S_SHIFT:
            begin
                if (shift_more)
                begin
                    rd_en = 1'b1;
                    if (op_reg == OP_INSERT)
                    begin
                        rd_addr = AW'(idx_reg - 1'b1);
                    end
                    else
                    begin
                        rd_addr = AW'(idx_reg + 1'b1);
                    end
                end
                else if (op_reg == OP_INSERT)
                begin
                    wr_en   = 1'b1;
                    wr_addr = lo_reg[AW-1:0];
                    wr_data = {key_reg, val_reg};
                end
            end
            S_MOVE:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            op_reg    <= OP_NONE;
            lo_reg    <= '0;
            hi_reg    <= '0;
            idx_reg   <= '0;
            key_reg   <= '0;
            val_reg   <= '0;
            r_status  <= ST_MISSING;
            r_value   <= '0;
            r_slot    <= '0;
            r_count   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        op_reg  <= q_kind;
                        key_reg <= q_key;
                        val_reg <= q_value;
                        lo_reg  <= '0;
                        hi_reg  <= cnt_reg;
                        if (q_kind == OP_NONE)
                        begin
                            r_status  <= ST_MISSING;
                            r_value   <= '0;
                            r_slot    <= '0;
                            r_count   <= cnt_reg;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_PROBE;
                        end
                    end
                end
                S_PROBE:
                begin
                    state_reg <= (lo_reg < hi_reg) ? S_WAIT : S_DECIDE;
                end
                S_WAIT:
                begin
                    if (go_right)
                    begin
                        lo_reg <= CW'(mid + 1'b1);
                    end
                    else
                    begin
                        hi_reg <= mid;
                    end
                    state_reg <= S_PROBE;
                end
                S_DECIDE:
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        if (cnt_reg >= CW'(CAPACITY))
                        begin
                            r_status  <= ST_FULL;
                            r_value   <= '0;
                            r_slot    <= lo_reg;
                            r_count   <= cnt_reg;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            idx_reg   <= cnt_reg;
                            state_reg <= S_SHIFT;
                        end
                    end
                    else if (lo_reg < cnt_reg)
                    begin
                        state_reg <= S_MATCH;
                    end
                    else
                    begin
                        r_status  <= ST_MISSING;
                        r_value   <= '0;
                        r_slot    <= lo_reg;
                        r_count   <= cnt_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_MATCH:
                begin
                    // entry at lo is now in rd_reg
                    if (rd_key == key_reg)
                    begin
                        if (op_reg == OP_FIND)
                        begin
                            r_status  <= ST_OK;
                            r_value   <= rd_reg[VALUE_BITS-1:0];
                            r_slot    <= lo_reg;
                            r_count   <= cnt_reg;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            idx_reg   <= lo_reg;
                            state_reg <= S_SHIFT;
                        end
                    end
                    else
                    begin
                        r_status  <= ST_MISSING;
                        r_value   <= '0;
                        r_slot    <= lo_reg;
                        r_count   <= cnt_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_SHIFT:
                begin
                    if (shift_more)
                    begin
                        state_reg <= S_MOVE;
                    end
                    else
                    begin
                        r_status  <= ST_OK;
                        r_value   <= '0;
                        r_slot    <= lo_reg;
                        state_reg <= S_OUT;
                        if (op_reg == OP_INSERT)
                        begin
                            r_count <= CW'(cnt_reg + 1'b1);
                            cnt_reg <= CW'(cnt_reg + 1'b1);
                        end
                        else
                        begin
                            r_count <= CW'(cnt_reg - 1'b1);
                            cnt_reg <= CW'(cnt_reg - 1'b1);
                        end
                    end
                end
                S_MOVE:
                begin
                    // neighbor read in SHIFT is written to idx this cycle
                    if (op_reg == OP_INSERT)
                    begin
                        idx_reg <= CW'(idx_reg - 1'b1);
                    end
                    else
                    begin
                        idx_reg <= CW'(idx_reg + 1'b1);
                    end
                    state_reg <= S_SHIFT;
                end
                S_OUT:
                begin
                    if (r_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* src/sorted_key_value_leaf_table.sv */
// Top level of the sorted key/value leaf table.
// Depends on skvlt_pkg, skvlt_if, skvlt_front and skvlt_back.
`timescale 1ns / 1ps
// Usage:
//   req (sink): kind, search_key, entry_value. One transfer per operation.
//   rsp (source): status, found_value, slot, entry_count. One transfer per request.
//   A front queue of two entries takes requests while the back end works,
//   so requests may arrive while a result waits on a stalled receiver.
//   A request is registered in the front queue before the back end takes it.
//   Back end: a binary search of up to 7 probes, each a PROBE and a WAIT state
//   through the single registered memory read port, then DECIDE, and MATCH for
//   find and erase, before the result is registered for output.
//   Insert and erase then move entries, a read in SHIFT and a write in MOVE
//   per moved entry, up to 63 moves.
//   After the result transfer the back end returns to IDLE before the next item.
//   The result register holds until the receiver takes it; the back end
//   waits meanwhile and the front queue fills, then req.ready drops.
//   Reset clears the entry count; memory contents are not cleared and are
//   never read beyond the count.
module sorted_key_value_leaf_table (
    input  logic clk,
    input  logic rst_n,
    skvlt_req_if.sink   req,
    skvlt_rsp_if.source rsp
);
    import skvlt_pkg::*;

    localparam int QW = 2 + KEY_BITS + VALUE_BITS;

    logic          q_valid, q_ready;
    logic [QW-1:0] in_word, q_word;
    status_t       r_status;
    logic [VALUE_BITS-1:0] r_value;
    logic [CW-1:0] r_slot, r_count;

    assign in_word = {req.data.kind, req.data.search_key[KEY_BITS-1:0],
                      req.data.entry_value[VALUE_BITS-1:0]};

    skvlt_front #(.W(QW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready), .in_data(in_word),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_word)
    );

    skvlt_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_kind(op_t'(q_word[QW-1 -: 2])),
        .q_key(q_word[KEY_BITS+VALUE_BITS-1:VALUE_BITS]),
        .q_value(q_word[VALUE_BITS-1:0]),
        .r_valid(rsp.valid), .r_ready(rsp.ready),
        .r_status(r_status), .r_value(r_value), .r_slot(r_slot), .r_count(r_count)
    );

    assign rsp.data.status      = r_status;
    assign rsp.data.found_value = r_value;
    assign rsp.data.slot        = r_slot;
    assign rsp.data.entry_count = r_count;

    // count never exceeds capacity
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (r_count <= CW'(CAPACITY))) else $error("count overflow");
    // a full report always carries a count equal to capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && r_status == ST_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("full with wrong count");
    // held result stays while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
        else $error("result moved");
endmodule
